>>> hdl/pfx_pkg.sv
// Shared constants, types and helper functions for the postfix evaluator.
package pfx_pkg;

   localparam int STACK_DEPTH_DEF = 64;
   localparam int FRAC_DIGITS     = 4;
   localparam int CHAR_W          = 8;
   localparam int VALUE_W         = 48;
   localparam int STATUS_W        = 2;

   localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CH_POINT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_STAR    = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_SAT   = 2'd3;

   localparam logic [1:0] OP_NONE = 2'd0;
   localparam logic [1:0] OP_ADD  = 2'd1;
   localparam logic [1:0] OP_MUL  = 2'd2;
   localparam logic [1:0] OP_NL   = 2'd3;

   typedef struct packed {
      logic digit_en;
      logic point_en;
      logic prod_en;
      logic clear_en;
   } num_ctl_type;

   // ceil(2^(16+t)/10^k); floor(frac * recip >> t) is exact for every frac below 10^k
   function automatic logic [29:0] frac_recip(input logic [2:0] cnt);
      logic [29:0] r;
      unique case (cnt)
         3'd1:    r = 30'd838861;
         3'd2:    r = 30'd10737419;
         3'd3:    r = 30'd68719477;
         3'd4:    r = 30'd879609303;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic [1:0] char_op(input logic [CHAR_W-1:0] c);
      logic [1:0] op;
      priority if (c == CH_PLUS) begin
         op = OP_ADD;
      end else if (c == CH_STAR) begin
         op = OP_MUL;
      end else if (c == CH_NEWLINE) begin
         op = OP_NL;
      end else begin
         op = OP_NONE;
      end
      return op;
   endfunction

endpackage

>>> hdl/pfx_req_if.sv
// Character input channel: valid/ready handshake carrying one ASCII code per beat.
interface pfx_req_if;
   import pfx_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

>>> hdl/pfx_rsp_if.sv
// Result channel: valid/ready handshake carrying value and status per beat.
interface pfx_rsp_if;
   import pfx_pkg::*;
   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  value;
   logic [STATUS_W-1:0] status;
   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

>>> hdl/pfx_numacc.sv
// Number collector: gathers decimal digits and converts them to 32.16 fixed point.
module pfx_numacc (
   input  logic                 clock,
   input  logic                 reset,
   input  pfx_pkg::num_ctl_type ctl,
   input  logic [3:0]           digit,
   output logic                 in_number,
   output logic                 digit_sat,
   output logic [47:0]          value
);
   import pfx_pkg::*;

   logic [31:0] int_part_ff, int_part_in;
   logic [13:0] frac_ff, frac_in;
   logic [2:0]  fcnt_ff, fcnt_in;
   logic        after_point_ff, after_point_in;
   logic        in_number_ff, in_number_in;
   logic [43:0] prod_ff;
   logic [35:0] int_x10;
   logic [17:0] frac_x10;
   logic        int_ovf;
   logic [15:0] frac16;

   always_comb begin
      int_x10  = (36'(int_part_ff) << 3) + (36'(int_part_ff) << 1) + 36'(digit);
      frac_x10 = (18'(frac_ff) << 3) + (18'(frac_ff) << 1) + 18'(digit);
      int_ovf  = |int_x10[35:32];

      int_part_in    = int_part_ff;
      frac_in        = frac_ff;
      fcnt_in        = fcnt_ff;
      after_point_in = after_point_ff;
      in_number_in   = in_number_ff;
      priority if (ctl.clear_en) begin
         int_part_in    = '0;
         frac_in        = '0;
         fcnt_in        = '0;
         after_point_in = 1'b0;
         in_number_in   = 1'b0;
      end else if (ctl.digit_en) begin
         in_number_in = 1'b1;
         if (after_point_ff) begin
            // drop digits past the kept fraction length
            if (fcnt_ff < 3'(FRAC_DIGITS)) begin
               frac_in = frac_x10[13:0];
               fcnt_in = fcnt_ff + 3'd1;
            end
         end else begin
            int_part_in = int_ovf ? '1 : int_x10[31:0];
         end
      end else if (ctl.point_en) begin
         in_number_in   = 1'b1;
         after_point_in = 1'b1;
      end else begin
         // hold the collected number
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         int_part_ff    <= '0;
         frac_ff        <= '0;
         fcnt_ff        <= '0;
         after_point_ff <= 1'b0;
         in_number_ff   <= 1'b0;
      end else begin
         int_part_ff    <= int_part_in;
         frac_ff        <= frac_in;
         fcnt_ff        <= fcnt_in;
         after_point_ff <= after_point_in;
         in_number_ff   <= in_number_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.prod_en) begin
         prod_ff <= 44'(frac_ff) * 44'(frac_recip(fcnt_ff));
      end
   end

   always_comb begin
      unique case (fcnt_ff)
         3'd1:    frac16 = prod_ff[22:7];
         3'd2:    frac16 = prod_ff[29:14];
         3'd3:    frac16 = prod_ff[35:20];
         3'd4:    frac16 = prod_ff[42:27];
         default: frac16 = '0;
      endcase
   end

   assign value     = {int_part_ff, frac16};
   assign in_number = in_number_ff;
   assign digit_sat = ctl.digit_en && !after_point_ff && int_ovf;

endmodule

>>> hdl/pfx_fixmul.sv
// 32.16 fixed-point multiplier with saturation at the full 48-bit range.
module pfx_fixmul (
   input  logic        clock,
   input  logic        en,
   input  logic [47:0] a,
   input  logic [47:0] b,
   output logic [47:0] result,
   output logic        sat
);
   logic [63:0] lo_ff;
   logic [47:0] mid_a_ff, mid_b_ff;
   logic        hi_nz_ff;
   logic [48:0] mid;
   logic [64:0] sum;

   // registered step: partial products, split to fit 32x32 multipliers
   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff    <= 64'(a[31:0]) * 64'(b[31:0]);
         mid_a_ff <= 48'(a[31:0]) * 48'(b[47:32]);
         mid_b_ff <= 48'(a[47:32]) * 48'(b[31:0]);
         hi_nz_ff <= (|a[47:32]) && (|b[47:32]);
      end
   end

   // combinational step: combine; saturate when the full product reaches 2^64
   always_comb begin
      mid    = {1'b0, mid_a_ff} + {1'b0, mid_b_ff};
      sum    = {1'b0, mid[31:0], 32'd0} + {1'b0, lo_ff};
      sat    = hi_nz_ff || (|mid[48:32]) || sum[64];
      result = sat ? '1 : sum[63:16];
   end

endmodule

>>> hdl/postfix_expression_evaluator.sv
// Postfix evaluator top level: input holding register, sequencer, stack memory, result register.
//
// Feed ASCII characters on req_ch, one per beat; read results on rsp_ch.
// Digits and '.' build a number; any other character pushes a pending number
// as 32.16 unsigned fixed point. '+' and '*' pop two entries and push the sum
// or product (saturating); a newline pops the top and returns it with status
// (0 ok, 1 underflow, 2 overflow, 3 saturated), the first error since the last
// newline. Other characters only end a number.
// Per character: a digit or point only updates the number; a character ending a
// number first runs the fraction multiply, then the push, before it runs itself;
// '*' goes through the split multiplier; '+', '*' and newline then read the stack
// memory to refill the cached second entry when 3 or more entries were on the
// stack. The top two entries live in registers; the stack memory is written on
// every push.
// A one-entry holding register takes the next character while the sequencer
// works. A newline result is registered in the output register when it is
// processed; if rsp_ch stalls with a result waiting, the next newline holds
// until the register frees, and characters back up through req_ch.ready.
// Synchronous reset empties the stack, clears the number and sticky error and
// drops any held character or result; memory contents are not cleared.
module postfix_expression_evaluator #(
   parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   pfx_req_if.sink      req_ch,
   pfx_rsp_if.source    rsp_ch
);
   import pfx_pkg::*;

   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

   localparam logic [2:0] S_RUN  = 3'd0;
   localparam logic [2:0] S_FIN  = 3'd1;
   localparam logic [2:0] S_OP   = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_FILL = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic                buf_valid_ff, buf_valid_in;
   logic [CHAR_W-1:0]   buf_char_ff;
   logic [1:0]          buf_op;
   logic                consume, accept;
   logic [1:0]          op_ff, op_in;
   logic [CNT_W-1:0]    depth_ff, depth_in, depth_m1, depth_m2, depth_m3;
   logic [VALUE_W-1:0]  top_ff, top_in, nos_ff, nos_in;
   logic [STATUS_W-1:0] sticky_ff, sticky_in;
   logic                out_valid_ff, out_valid_in, out_load, out_free;
   logic [VALUE_W-1:0]  out_value_ff, out_value_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;

   logic                mem_we, mem_re;
   logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
   logic [VALUE_W-1:0]  mem_wdata, rd_data_ff;
   logic [VALUE_W-1:0]  stack_mem [STACK_DEPTH];

   logic                exec_go, wb_go, wb_sat, err_go, clear_sticky;
   logic [1:0]          exec_op;
   logic [VALUE_W-1:0]  wb_value;
   logic [STATUS_W-1:0] err_code;
   logic [VALUE_W:0]    add_sum;

   num_ctl_type         num_ctl;
   logic                num_in_number, num_digit_sat;
   logic [VALUE_W-1:0]  num_value;

   logic                mul_en, mul_sat;
   logic [VALUE_W-1:0]  mul_result;

   pfx_numacc u_numacc (
      .clock     (clock),
      .reset     (reset),
      .ctl       (num_ctl),
      .digit     (buf_char_ff[3:0]),
      .in_number (num_in_number),
      .digit_sat (num_digit_sat),
      .value     (num_value)
   );

   pfx_fixmul u_fixmul (
      .clock  (clock),
      .en     (mul_en),
      .a      (top_ff),
      .b      (nos_ff),
      .result (mul_result),
      .sat    (mul_sat)
   );

   assign buf_op   = char_op(buf_char_ff);
   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign depth_m1 = depth_ff - CNT_W'(1);
   assign depth_m2 = depth_ff - CNT_W'(2);
   assign depth_m3 = depth_ff - CNT_W'(3);
   assign add_sum  = {1'b0, top_ff} + {1'b0, nos_ff};

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      depth_in      = depth_ff;
      top_in        = top_ff;
      nos_in        = nos_ff;
      consume       = 1'b0;
      num_ctl       = '0;
      exec_go       = 1'b0;
      exec_op       = OP_NONE;
      wb_go         = 1'b0;
      wb_value      = mul_result;
      wb_sat        = 1'b0;
      err_go        = 1'b0;
      err_code      = ST_OK;
      clear_sticky  = 1'b0;
      out_load      = 1'b0;
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = depth_m2[ADDR_W-1:0];
      mem_wdata     = wb_value;
      mem_re        = 1'b0;
      mem_raddr     = depth_m3[ADDR_W-1:0];
      mul_en        = 1'b0;

      unique case (state_ff)
         S_RUN: begin
            if (buf_valid_ff) begin
               priority if (is_digit(buf_char_ff)) begin
                  consume          = 1'b1;
                  num_ctl.digit_en = 1'b1;
                  err_go           = num_digit_sat;
                  err_code         = ST_SAT;
               end else if (buf_char_ff == CH_POINT) begin
                  consume          = 1'b1;
                  num_ctl.point_en = 1'b1;
               end else if (num_in_number) begin
                  // convert the pending number first, run the operator after the push
                  consume         = 1'b1;
                  num_ctl.prod_en = 1'b1;
                  op_in           = buf_op;
                  state_in        = S_FIN;
               end else if (buf_op != OP_NL || out_free) begin
                  consume = 1'b1;
                  exec_go = 1'b1;
                  exec_op = buf_op;
               end else begin
                  // hold the newline until the result register frees
               end
            end
         end
         S_FIN: begin
            num_ctl.clear_en = 1'b1;
            if (depth_ff == CNT_W'(STACK_DEPTH)) begin
               err_go   = 1'b1;
               err_code = ST_OVER;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = depth_ff[ADDR_W-1:0];
               mem_wdata = num_value;
               top_in    = num_value;
               nos_in    = top_ff;
               depth_in  = depth_ff + CNT_W'(1);
            end
            state_in = (op_ff == OP_NONE) ? S_RUN : S_OP;
         end
         S_OP: begin
            if (op_ff != OP_NL || out_free) begin
               exec_go = 1'b1;
               exec_op = op_ff;
            end
         end
         S_MUL: begin
            wb_go    = 1'b1;
            wb_value = mul_result;
            wb_sat   = mul_sat;
         end
         S_FILL: begin
            nos_in   = rd_data_ff;
            state_in = S_RUN;
         end
         default: state_in = S_RUN;
      endcase

      if (exec_go) begin
         unique case (exec_op)
            OP_ADD: begin
               if (depth_ff < CNT_W'(2)) begin
                  err_go   = 1'b1;
                  err_code = ST_UNDER;
                  state_in = S_RUN;
               end else begin
                  wb_go    = 1'b1;
                  wb_value = add_sum[VALUE_W] ? '1 : add_sum[VALUE_W-1:0];
                  wb_sat   = add_sum[VALUE_W];
               end
            end
            OP_MUL: begin
               if (depth_ff < CNT_W'(2)) begin
                  err_go   = 1'b1;
                  err_code = ST_UNDER;
                  state_in = S_RUN;
               end else begin
                  mul_en   = 1'b1;
                  state_in = S_MUL;
               end
            end
            OP_NL: begin
               out_load     = 1'b1;
               clear_sticky = 1'b1;
               if (depth_ff == '0) begin
                  out_value_in  = '0;
                  out_status_in = (sticky_ff == ST_OK) ? ST_UNDER : sticky_ff;
                  state_in      = S_RUN;
               end else begin
                  out_value_in  = top_ff;
                  out_status_in = sticky_ff;
                  top_in        = nos_ff;
                  depth_in      = depth_m1;
                  if (depth_ff >= CNT_W'(3)) begin
                     mem_re   = 1'b1;
                     state_in = S_FILL;
                  end else begin
                     state_in = S_RUN;
                  end
               end
            end
            default: state_in = S_RUN;
         endcase
      end

      // pop two, push the result to the lower slot, refill the second entry if 3+ were held
      if (wb_go) begin
         mem_we    = 1'b1;
         mem_waddr = depth_m2[ADDR_W-1:0];
         mem_wdata = wb_value;
         top_in    = wb_value;
         depth_in  = depth_m1;
         err_go    = wb_sat;
         err_code  = ST_SAT;
         if (depth_ff >= CNT_W'(3)) begin
            mem_re   = 1'b1;
            state_in = S_FILL;
         end else begin
            state_in = S_RUN;
         end
      end
   end

   always_comb begin
      priority if (clear_sticky) begin
         sticky_in = ST_OK;
      end else if (err_go && sticky_ff == ST_OK) begin
         sticky_in = err_code;
      end else begin
         sticky_in = sticky_ff;
      end
   end

   // holding register: take a new beat when empty or when its character is consumed
   assign req_ch.ready = !buf_valid_ff || consume;
   assign accept       = req_ch.valid && req_ch.ready;
   assign buf_valid_in = accept || (buf_valid_ff && !consume);
   assign out_valid_in = out_load || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RUN;
         buf_valid_ff <= 1'b0;
         op_ff        <= OP_NONE;
         depth_ff     <= '0;
         sticky_ff    <= ST_OK;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         buf_valid_ff <= buf_valid_in;
         op_ff        <= op_in;
         depth_ff     <= depth_in;
         sticky_ff    <= sticky_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         buf_char_ff <= req_ch.char_code;
      end
      top_ff <= top_in;
      nos_ff <= nos_in;
      if (out_load) begin
         out_value_ff  <= out_value_in;
         out_status_ff <= out_status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= stack_mem[mem_raddr];
      end
   end

   assign rsp_ch.valid  = out_valid_ff;
   assign rsp_ch.value  = out_value_ff;
   assign rsp_ch.status = out_status_ff;

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack depth beyond capacity");

   a_mem_no_collide: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("stack read and write hit the same entry");

   a_fill_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL) |-> $past(mem_re))
      else $error("refill without a preceding stack read");

   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!out_valid_ff || rsp_ch.ready))
      else $error("result overwrites an undelivered beat");

   a_consume_held: assert property (@(posedge clock) disable iff (reset)
      consume |-> buf_valid_ff)
      else $error("character consumed from empty holding register");

endmodule

>>> test/tb_postfix_expression_evaluator.sv
// Self-checking testbench for the postfix evaluator: character driver, result checker.
`timescale 1ns / 1ps

module tb_postfix_expression_evaluator;
   import pfx_pkg::*;

   localparam int DEPTH       = STACK_DEPTH_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 40;
   localparam int RANDOM_CHARS = 700;

   typedef struct packed {
      logic [VALUE_W-1:0]  value;
      logic [STATUS_W-1:0] status;
   } eval_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pfx_req_if req_ch ();
   pfx_rsp_if rsp_ch ();

   postfix_expression_evaluator #(.STACK_DEPTH(DEPTH)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   logic [CHAR_W-1:0] pending_chars[$];
   eval_result_type   expected_results[$];

   // Predicted evaluator state
   logic [VALUE_W-1:0]  operand_mem [DEPTH];
   int unsigned         operand_cnt = 0;
   logic [31:0]         int_acc     = '0;
   logic [13:0]         frac_acc    = '0;
   int unsigned         frac_cnt    = 0;
   bit                  seen_point  = 1'b0;
   bit                  building    = 1'b0;
   logic [STATUS_W-1:0] first_err   = ST_OK;

   int fail_count     = 0;
   int chars_accepted = 0;
   int results_seen   = 0;
   int under_seen     = 0;
   int over_seen      = 0;
   int sat_seen       = 0;
   int cycle_count    = 0;

   int burst_left = 1;
   int gap_left   = 0;
   int stall_left = 0;
   int calm_left  = 100;
   bit steady     = 1'b1;

   function automatic longint unsigned ten_to(int unsigned n);
      longint unsigned p;
      p = 1;
      repeat (n) p = p * 10;
      return p;
   endfunction

   // keep only the first error since the last newline
   function automatic void note_error(logic [STATUS_W-1:0] code);
      if (first_err == ST_OK) first_err = code;
   endfunction

   function automatic void push_operand(logic [VALUE_W-1:0] v);
      if (operand_cnt >= DEPTH) begin
         note_error(ST_OVER);
      end else begin
         operand_mem[operand_cnt] = v;
         operand_cnt++;
      end
   endfunction

   function automatic void close_number();
      longint unsigned frac;
      logic [VALUE_W-1:0] v;
      if (!building) return;
      frac = 0;
      if (frac_cnt > 0) frac = (longint'(frac_acc) << 16) / ten_to(frac_cnt);
      v = {int_acc, 16'h0000} + VALUE_W'(frac[15:0]);
      push_operand(v);
      int_acc    = '0;
      frac_acc   = '0;
      frac_cnt   = 0;
      seen_point = 1'b0;
      building   = 1'b0;
   endfunction

   function automatic void combine_top(bit is_mul);
      logic [VALUE_W-1:0]   a;
      logic [VALUE_W-1:0]   b;
      logic [VALUE_W-1:0]   r;
      logic [2*VALUE_W-1:0] prod;
      logic [VALUE_W:0]     total;
      bit                   sat;
      if (operand_cnt < 2) begin
         note_error(ST_UNDER);
         return;
      end
      a = operand_mem[operand_cnt-1];
      b = operand_mem[operand_cnt-2];
      operand_cnt -= 2;
      if (is_mul) begin
         prod = (2*VALUE_W)'(a) * (2*VALUE_W)'(b);
         // product shifted by 16 must fit in 48 bits
         sat = (prod[2*VALUE_W-1:64] != '0);
         r = sat ? '1 : prod[63:16];
      end else begin
         total = (VALUE_W+1)'(a) + (VALUE_W+1)'(b);
         sat = total[VALUE_W];
         r = sat ? '1 : total[VALUE_W-1:0];
      end
      if (sat) note_error(ST_SAT);
      push_operand(r);
   endfunction

   function automatic void evaluate_char(logic [CHAR_W-1:0] c);
      eval_result_type res;
      logic [7:0]      d;
      longint unsigned wide;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d = c - CH_ZERO;
         building = 1'b1;
         if (seen_point) begin
            if (frac_cnt < FRAC_DIGITS) begin
               frac_acc = 14'(frac_acc * 10 + d);
               frac_cnt++;
            end
         end else begin
            wide = 64'(int_acc) * 64'd10 + 64'(d);
            if (wide > 64'hFFFF_FFFF) begin
               wide = 64'hFFFF_FFFF;
               note_error(ST_SAT);
            end
            int_acc = wide[31:0];
         end
         return;
      end
      if (c == CH_POINT) begin
         building   = 1'b1;
         seen_point = 1'b1;
         return;
      end
      close_number();
      if (c == CH_PLUS) begin
         combine_top(1'b0);
      end else if (c == CH_STAR) begin
         combine_top(1'b1);
      end else if (c == CH_NEWLINE) begin
         if (operand_cnt == 0) begin
            note_error(ST_UNDER);
            res.value = '0;
         end else begin
            operand_cnt--;
            res.value = operand_mem[operand_cnt];
         end
         res.status = first_err;
         first_err  = ST_OK;
         expected_results.push_back(res);
      end
   endfunction

   // ---------------- stimulus builders ----------------

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) pending_chars.push_back(s[i]);
   endtask

   function automatic string rand_digits(int n);
      string s;
      s = "";
      repeat (n) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
      return s;
   endfunction

   // any character the evaluator treats as a plain separator
   function automatic logic [CHAR_W-1:0] filler_char();
      logic [CHAR_W-1:0] c;
      do begin
         c = CHAR_W'($urandom_range(0, 255));
      end while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_POINT || c == CH_PLUS ||
                 c == CH_STAR || c == CH_NEWLINE);
      return c;
   endfunction

   task automatic add_number();
      int pick;
      string s;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         s = $sformatf("%0d", $urandom_range(0, 999));
      end else if (pick < 72) begin
         s = {$sformatf("%0d", $urandom_range(0, 99)), ".", rand_digits($urandom_range(1, 6))};
      end else if (pick < 84) begin
         s = {rand_digits($urandom_range(0, 2)) , $sformatf("%0d", $urandom())};
         if ($urandom_range(0, 1)) s = {s, ".", rand_digits($urandom_range(1, 4))};
      end else if (pick < 91) begin
         s = {"1", rand_digits($urandom_range(10, 13))};
      end else if (pick < 95) begin
         s = {".", rand_digits($urandom_range(0, 5))};
      end else begin
         s = {rand_digits($urandom_range(1, 3)), ".", rand_digits($urandom_range(0, 3)), ".",
              rand_digits($urandom_range(0, 3))};
      end
      add_text(s);
   endtask

   task automatic add_separator();
      if ($urandom_range(0, 3) != 0) pending_chars.push_back(" ");
      else pending_chars.push_back(filler_char());
   endtask

   task automatic add_operator();
      if ($urandom_range(0, 1)) pending_chars.push_back(CH_PLUS);
      else pending_chars.push_back(CH_STAR);
      if ($urandom_range(0, 2) == 0) pending_chars.push_back(" ");
   endtask

   // well-formed expression: leaves the stack depth unchanged
   task automatic add_expression();
      int n;
      int pushed;
      int live;
      n = $urandom_range(1, 6);
      pushed = 0;
      live = 0;
      while (pushed < n || live > 1) begin
         if (pushed < n && (live < 2 || $urandom_range(0, 1))) begin
            add_number();
            add_separator();
            pushed++;
            live++;
         end else begin
            add_operator();
            live--;
         end
      end
      pending_chars.push_back(CH_NEWLINE);
   endtask

   task automatic add_broken();
      case ($urandom_range(0, 2))
         0: begin
            add_number();
            add_separator();
            add_number();
            pending_chars.push_back(CH_NEWLINE);
         end
         1: begin
            add_number();
            add_operator();
            add_operator();
            pending_chars.push_back(CH_NEWLINE);
         end
         default: begin
            add_operator();
            add_number();
            pending_chars.push_back(CH_NEWLINE);
         end
      endcase
   endtask

   task automatic add_noise();
      repeat ($urandom_range(1, 8)) pending_chars.push_back(CHAR_W'($urandom_range(0, 255)));
   endtask

   // overfill the stack, then pop everything back out
   task automatic add_flood();
      repeat ($urandom_range(DEPTH + 1, DEPTH + 6)) begin
         add_text($sformatf("%0d", $urandom_range(0, 9)));
         add_separator();
      end
      repeat (DEPTH + 8) pending_chars.push_back(CH_NEWLINE);
   endtask

   // ---------------- driver ----------------

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (pending_chars.size() > 0) begin
            req_ch.valid     <= 1'b1;
            req_ch.char_code <= pending_chars.pop_front();
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // ---------------- result sink stall pattern ----------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (calm_left > 0) begin
            calm_left--;
         end else begin
            steady    = !steady;
            calm_left = $urandom_range(50, 300);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (steady || $urandom_range(0, 3) != 0) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            stall_left = $urandom_range(0, 7);
            rsp_ch.ready <= 1'b0;
         end
      end
   end

   // ---------------- monitor and checker ----------------

   always @(posedge clock) begin
      eval_result_type want;
      if (!reset) begin
         // predict first: a newline beat cannot return its result in the same cycle
         if (req_ch.valid && req_ch.ready) begin
            evaluate_char(req_ch.char_code);
            chars_accepted++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               $error("unexpected result beat: value %h status %0d",
                      rsp_ch.value, rsp_ch.status);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_ch.value !== want.value) begin
                  $error("value: expected %h, actual %h", want.value, rsp_ch.value);
                  fail_count++;
               end
               if (rsp_ch.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                  fail_count++;
               end
               case (want.status)
                  ST_UNDER: under_seen++;
                  ST_OVER:  over_seen++;
                  ST_SAT:   sat_seen++;
                  default:  ;
               endcase
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still owed",
                  cycle_count, expected_results.size());
         $display("postfix_expression_evaluator: mismatch");
         $finish;
      end
   end

   // ---------------- sequence ----------------

   initial begin
      int random_chars;
      int mark;
      bit flooded;
      req_ch.valid     = 1'b0;
      req_ch.char_code = '0;
      rsp_ch.ready     = 1'b0;

      // directed: empty newline, operator underflow, lone point,
      // integer saturation, repeated point with extra fraction digits
      add_text("\n");
      add_text("*\n");
      add_text(".\n");
      add_text("4294967296\n");
      add_text("1.2.56789");
      pending_chars.push_back(8'hFF);
      add_text("3*");
      pending_chars.push_back(8'h00);
      add_text("\n");

      random_chars = 0;
      flooded = 1'b0;
      while (random_chars < RANDOM_CHARS) begin
         mark = pending_chars.size();
         if (!flooded && random_chars > RANDOM_CHARS / 2) begin
            add_flood();
            flooded = 1'b1;
         end else begin
            case ($urandom_range(0, 19))
               0, 1:    add_broken();
               2:       add_noise();
               3:       pending_chars.push_back(CH_NEWLINE);
               default: add_expression();
            endcase
         end
         random_chars += pending_chars.size() - mark;
      end
      pending_chars.push_back(CH_NEWLINE);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_chars.size() != 0 || req_ch.valid) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("%0d characters evaluated, %0d results checked", chars_accepted, results_seen);
      $display("error statuses seen: %0d underflow, %0d overflow, %0d saturated",
               under_seen, over_seen, sat_seen);
      if (fail_count == 0) begin
         $display("postfix_expression_evaluator: match");
      end else begin
         $display("postfix_expression_evaluator: mismatch");
      end
      $finish;
   end

endmodule
